// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

  // Item kinds
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_GET = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_GIVEN = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LUSE = 3'b010,
    S_DRD  = 3'b100
  } state_t;

  localparam int ID_W  = 16;
  localparam int REF_W = 32;
  localparam int ENTRY_W = 2 * REF_W + ID_W;

endpackage

// ===== rtl/core/strict_priority_task_queue.sv =====
`timescale 1ns / 1ps
// For an add with a priority of LEVELS or above or a get with no task, the result is formed in
// the idle state; for any other add (taken or refused as full) it is formed in the level-record
// state, and for a get that returns a task in the task-read state after it; done is registered.
// Busy covers the level-record read-modify-write and, for a get, the read of the task memory;
// a new item is accepted only while the sequencer is idle.
// Results are strobed on done for one cycle; the receiver cannot stall them.
// Reset clears the sequencer, the level-record valid bits and the non-empty flags at once.
module strict_priority_task_queue import spq_pkg::*; #(
  parameter int LEVELS      = 16,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [3:0]  priority_req,
  input  logic [15:0] task_id,
  input  logic [31:0] task_ref,
  input  logic [31:0] argument_ref,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  out_priority,
  output logic [15:0] out_task_id,
  output logic [31:0] out_task_ref,
  output logic [31:0] out_argument_ref
);

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SLOTS  = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int REC_W  = 2 * PTR_W + CNT_W;

  state_t state;

  // Captured beat
  logic              req_kind;
  logic [LVL_W-1:0]  sel_lvl;
  logic [ADDR_W-1:0] base;
  logic [ID_W-1:0]   req_id;
  logic [REF_W-1:0]  req_tref;
  logic [REF_W-1:0]  req_aref;

  logic [LEVELS-1:0] lvl_valid;

  logic             accept;
  logic             go;
  logic [8:0]       prio_ext;
  logic             prio_ok;
  logic [LVL_W-1:0] req_lvl;
  logic             pick_found;
  logic [LVL_W-1:0] pick_lvl;

  // Level record memory: {head, tail, count}
  logic             lv_we;
  logic [REC_W-1:0] lv_wdata;
  logic [REC_W-1:0] lv_rdata;
  logic [REC_W-1:0] lv_rec;
  logic [PTR_W-1:0] lv_head;
  logic [PTR_W-1:0] lv_tail;
  logic [CNT_W-1:0] lv_cnt;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  logic             lv_full;

  // Task memory: {task_ref, argument_ref, task_id}
  logic               dr_we;
  logic               dr_re;
  logic [ADDR_W-1:0]  dr_waddr;
  logic [ADDR_W-1:0]  dr_raddr;
  logic [ENTRY_W-1:0] dr_wdata;
  logic [ENTRY_W-1:0] dr_rdata;

  // Result of this cycle
  logic        res_valid;
  status_t     res_status;
  logic [3:0]  res_prio;
  logic [15:0] res_id;
  logic [31:0] res_tref;
  logic [31:0] res_aref;
  logic [8:0]  sel_ext;

  assign busy = (state != S_IDLE);

  always_comb begin
    accept   = start && !busy;
    prio_ext = {5'd0, priority_req};
    prio_ok  = int'(prio_ext) < LEVELS;
    req_lvl  = (kind == KIND_ADD) ? prio_ext[LVL_W-1:0] : pick_lvl;
    go       = accept && ((kind == KIND_ADD) ? prio_ok : pick_found);
  end

  spq_pick #(
    .LEVELS(LEVELS)
  ) u_pick (
    .clk         (clk),
    .rst         (rst),
    .upd_en      (lv_we),
    .upd_lvl     (sel_lvl),
    .upd_nonempty((req_kind == KIND_ADD) || (lv_cnt != CNT_W'(1))),
    .found       (pick_found),
    .first_lvl   (pick_lvl)
  );

  // A level never written reads as an all-zero record
  always_comb begin
    lv_rec   = lvl_valid[sel_lvl] ? lv_rdata : '0;
    lv_head  = lv_rec[REC_W-1 -: PTR_W];
    lv_tail  = lv_rec[CNT_W +: PTR_W];
    lv_cnt   = lv_rec[CNT_W-1:0];
    lv_full  = (lv_cnt == CNT_W'(LEVEL_DEPTH));
    head_inc = (lv_head == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : lv_head + PTR_W'(1);
    tail_inc = (lv_tail == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : lv_tail + PTR_W'(1);

    lv_we    = (state == S_LUSE) && ((req_kind == KIND_GET) || !lv_full);
    lv_wdata = (req_kind == KIND_GET) ? {head_inc, lv_tail, lv_cnt - CNT_W'(1)}
                                      : {lv_head, tail_inc, lv_cnt + CNT_W'(1)};

    dr_we    = (state == S_LUSE) && (req_kind == KIND_ADD) && !lv_full;
    dr_waddr = base + ADDR_W'(lv_tail);
    dr_wdata = {req_tref, req_aref, req_id};
    dr_re    = (state == S_LUSE) && (req_kind == KIND_GET);
    dr_raddr = base + ADDR_W'(lv_head);
  end

  spq_ram #(
    .WIDTH(REC_W),
    .DEPTH(LEVELS)
  ) u_level_ram (
    .clk  (clk),
    .we   (lv_we),
    .waddr(sel_lvl),
    .wdata(lv_wdata),
    .re   (go),
    .raddr(req_lvl),
    .rdata(lv_rdata)
  );

  spq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_task_ram (
    .clk  (clk),
    .we   (dr_we),
    .waddr(dr_waddr),
    .wdata(dr_wdata),
    .re   (dr_re),
    .raddr(dr_raddr),
    .rdata(dr_rdata)
  );

  // Result selection; task fields stay zero unless a task is given
  always_comb begin
    res_valid  = 1'b0;
    res_status = ST_ADDED;
    res_prio   = '0;
    res_id     = '0;
    res_tref   = '0;
    res_aref   = '0;
    sel_ext    = 9'(sel_lvl);
    case (state)
      S_IDLE: begin
        if (accept && !go) begin
          res_valid  = 1'b1;
          res_status = (kind == KIND_ADD) ? ST_FULL : ST_EMPTY;
        end
      end
      S_LUSE: begin
        if (req_kind == KIND_ADD) begin
          res_valid  = 1'b1;
          res_status = lv_full ? ST_FULL : ST_ADDED;
        end
      end
      S_DRD: begin
        res_valid  = 1'b1;
        res_status = ST_GIVEN;
        res_prio   = sel_ext[3:0];
        res_id     = dr_rdata[ID_W-1:0];
        res_aref   = dr_rdata[ID_W +: REF_W];
        res_tref   = dr_rdata[ENTRY_W-1 -: REF_W];
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Sequencer: hold busy through the read-modify-write of the level record and, for a get, the task read
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      lvl_valid <= '0;
    end else begin
      done <= res_valid;
      if (lv_we) begin
        lvl_valid[sel_lvl] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (go) begin
            state <= S_LUSE;
          end
        end
        S_LUSE: begin
          state <= (req_kind == KIND_GET) ? S_DRD : S_IDLE;
        end
        S_DRD: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the accepted beat and precompute the level's base slot
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      sel_lvl  <= req_lvl;
      base     <= ADDR_W'(req_lvl) * ADDR_W'(LEVEL_DEPTH);
      req_id   <= task_id;
      req_tref <= task_ref;
      req_aref <= argument_ref;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_valid) begin
      status           <= res_status;
      out_priority     <= res_prio;
      out_task_id      <= res_id;
      out_task_ref     <= res_tref;
      out_argument_ref <= res_aref;
    end
  end

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) || $past(busy)))
    else $error("result strobe without an accepted beat");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat neither in work nor answered");

  a_get_level_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LUSE && req_kind == KIND_GET) |-> (lv_cnt != '0))
    else $error("encoder picked a level whose record is empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LUSE) |-> (lv_cnt <= CNT_W'(LEVEL_DEPTH)))
    else $error("level count above level depth");

endmodule

// ===== rtl/core/spq_ram.sv =====
`timescale 1ns / 1ps
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/spq_pick.sv =====
`timescale 1ns / 1ps
module spq_pick #(
  parameter int LEVELS = 16,
  localparam int LVL_W = $clog2(LEVELS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             upd_en,
  input  logic [LVL_W-1:0] upd_lvl,
  input  logic             upd_nonempty,
  output logic             found,
  output logic [LVL_W-1:0] first_lvl
);

  logic [LEVELS-1:0] nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else if (upd_en) begin
      nonempty[upd_lvl] <= upd_nonempty;
    end
  end

  // Lowest-numbered non-empty level wins
  always_comb begin
    found     = 1'b0;
    first_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        found     = 1'b1;
        first_lvl = LVL_W'(i);
      end
    end
  end

endmodule
